/* rtl/gfau_pkg.sv */
// GF(2^8) arithmetic unit package: request type, operation codes and field tables.
// Field polynomial 0x11D, alpha = 2. No dependencies.
package gfau_pkg;

  localparam int unsigned ElemW  = 8;
  localparam int unsigned KindW  = 3;
  localparam int unsigned ExpW   = 16;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned InUserW  = 4;
  localparam int unsigned OutDataW = 8;
  localparam logic [8:0]  FieldPoly = 9'h11D;
  localparam logic [7:0]  GroupOrder = 8'd255;

  typedef enum logic [KindW-1:0] {
    OpAdd  = 3'd0,
    OpMul  = 3'd1,
    OpDiv  = 3'd2,
    OpInv  = 3'd3,
    OpPow  = 3'd4,
    OpPoly = 3'd5
  } op_e;

  typedef struct packed {
    logic [KindW-1:0] req_type;
    logic [ElemW-1:0] operand_a;
    logic [ElemW-1:0] operand_b;
    logic [ExpW-1:0]  exponent;
    logic             poly_start;
  } req_t;

  typedef logic [255:0][ElemW-1:0] tbl_t;

  function automatic tbl_t build_exp();
    tbl_t       t;
    logic [8:0] v;
    v = 9'd1;
    for (int i = 0; i < 256; i++) begin
      t[i] = v[7:0];
      v = {v[7:0], 1'b0};
      if (v[8]) begin
        v = v ^ FieldPoly;
      end
    end
    return t;
  endfunction

  function automatic tbl_t build_log();
    tbl_t t;
    tbl_t e;
    e = build_exp();
    t = '0;
    for (int i = 0; i < 255; i++) begin
      t[e[i]] = i[7:0];
    end
    return t;
  endfunction

  localparam tbl_t ExpTbl = build_exp();
  localparam tbl_t LogTbl = build_log();

  // carry-less multiply with reduction, one partial product per bit
  function automatic logic [ElemW-1:0] gf_mul(input logic [ElemW-1:0] x,
                                              input logic [ElemW-1:0] y);
    logic [8:0]       a;
    logic [ElemW-1:0] p;
    a = {1'b0, x};
    p = '0;
    for (int i = 0; i < ElemW; i++) begin
      if (y[i]) begin
        p = p ^ a[7:0];
      end
      a = {a[7:0], 1'b0};
      if (a[8]) begin
        a = a ^ FieldPoly;
      end
    end
    return p;
  endfunction

endpackage

/* rtl/gf256_arith_unit.sv */
// Top level of the GF(2^8) arithmetic unit: input register, datapath, result register.
// Depends on gfau_pkg and gfau_alu.
//
// Usage: requests arrive on the s_axis channel, one per transfer; the operation
// code and the polynomial start flag ride in tuser, the operands and exponent in
// tdata. Each request gives exactly one result on m_axis, in order.
// From the input transfer to result valid, the request is held in the input
// register, the datapath (table lookups and one 8x8 multiply on the power path)
// settles, and the result lands in the output register.
// Throughput is one request per cycle while the receiver does not stall; the Horner
// accumulator is updated in the same cycle that the step moves into the result
// register, so polynomial steps may follow back to back.
// When the receiver stalls, the result register holds, the input register keeps
// its request and s_axis_tready drops only once both are full; nothing is lost.
// Reset clears both valid flags and the Horner accumulator.
module gf256_arith_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] operand_a, [15:8] operand_b, [31:16] exponent
  input  logic [gfau_pkg::InDataW-1:0]    s_axis_tdata,
  // [2:0] req_type, [3] poly_start
  input  logic [gfau_pkg::InUserW-1:0]    s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] result
  output logic [gfau_pkg::OutDataW-1:0]   m_axis_tdata
);
  import gfau_pkg::*;

  logic             in_valid_q, in_valid_d;
  req_t             in_req_q;
  logic             out_valid_q, out_valid_d;
  logic [ElemW-1:0] out_data_q;
  logic [ElemW-1:0] alu_result;
  logic             out_free, advance, take;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;
  assign take          = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = take || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready);

  gfau_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .req_i    (in_req_q),
    .result_o (alu_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_req_q.req_type   <= s_axis_tuser[KindW-1:0];
      in_req_q.poly_start <= s_axis_tuser[KindW];
      in_req_q.operand_a  <= s_axis_tdata[ElemW-1:0];
      in_req_q.operand_b  <= s_axis_tdata[2*ElemW-1:ElemW];
      in_req_q.exponent   <= s_axis_tdata[2*ElemW+ExpW-1:2*ElemW];
    end
    if (advance) begin
      out_data_q <= alu_result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* rtl/gfau_alu.sv */
// GF(2^8) operation datapath with the Horner accumulator.
// Depends on gfau_pkg for tables, codes and the request type.
module gfau_alu (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  gfau_pkg::req_t        req_i,
  output logic [gfau_pkg::ElemW-1:0] result_o
);
  import gfau_pkg::*;

  logic [ElemW-1:0] acc_q, acc_d;
  logic [ElemW-1:0] log_a, log_b, exp_raw;
  logic [ElemW-1:0] raw_mod, exp_mod, pow_idx, div_idx, inv_idx;
  logic [15:0]      pow_prod;
  logic [ElemW-1:0] horner;
  logic             a_zero, b_zero;

  // x mod 255 for a 16-bit value: 2^8 == 1 (mod 255)
  function automatic logic [7:0] fold255(input logic [15:0] x);
    logic [8:0] s;
    logic [7:0] r;
    s = {1'b0, x[15:8]} + {1'b0, x[7:0]};
    r = s[7:0] + {7'd0, s[8]};
    return (r == GroupOrder) ? 8'd0 : r;
  endfunction

  assign a_zero = (req_i.operand_a == '0);
  assign b_zero = (req_i.operand_b == '0);
  assign log_a  = LogTbl[req_i.operand_a];
  assign log_b  = LogTbl[req_i.operand_b];

  // 65536 == 1 (mod 255), so a negative exponent is one less than its raw residue
  assign raw_mod  = fold255(req_i.exponent);
  assign exp_mod  = !req_i.exponent[ExpW-1] ? raw_mod :
                    (raw_mod == '0) ? (GroupOrder - 8'd1) : (raw_mod - 8'd1);
  assign pow_prod = {8'd0, log_a} * {8'd0, exp_mod};
  assign pow_idx  = fold255(pow_prod);
  assign div_idx  = (log_a >= log_b) ? (log_a - log_b) : (log_a + (GroupOrder - log_b));
  assign inv_idx  = GroupOrder - log_a;

  assign horner = gf_mul(req_i.poly_start ? '0 : acc_q, req_i.operand_a) ^ req_i.operand_b;

  always_comb begin
    exp_raw = '0;
    case (req_i.req_type)
      OpDiv:   exp_raw = ExpTbl[div_idx];
      OpInv:   exp_raw = ExpTbl[inv_idx];
      OpPow:   exp_raw = ExpTbl[pow_idx];
      default: exp_raw = '0;
    endcase
  end

  always_comb begin
    result_o = '0;
    acc_d    = acc_q;
    case (req_i.req_type)
      OpAdd:  result_o = req_i.operand_a ^ req_i.operand_b;
      OpMul:  result_o = gf_mul(req_i.operand_a, req_i.operand_b);
      OpDiv:  result_o = (a_zero || b_zero) ? '0 : exp_raw;
      OpInv, OpPow: result_o = a_zero ? '0 : exp_raw;
      OpPoly: begin
        acc_d    = horner;
        result_o = horner;
      end
      default: result_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (fire_i) begin
      acc_q <= acc_d;
    end
  end

endmodule
